// ===== rtl/core/bmf_pkg.sv =====
// Shared types, constants and register indexes of the binary majority filter.
package bmf_pkg;

  // Default grid limits
  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 128;

  // Configuration port widths
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WALL_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS      = 2'd2;

  // Register reset values
  localparam logic [3:0] RESET_THRESHOLD = 4'd5;
  localparam logic [7:0] RESET_COLS      = 8'd128;
  localparam logic [7:0] RESET_ROWS      = 8'd128;

  // Smallest grid side
  localparam int MIN_SIDE = 3;

  // Input item
  typedef struct packed {
    logic cell_in;
    logic flush;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic cell_out;
    logic frame_last;
  } out_item_t;

  // Delay line control
  typedef struct packed {
    logic shift;
    logic restart;
  } line_ctrl_t;

endpackage

// ===== rtl/core/bmf_delay_line.sv =====
// Circular one-bit delay line of programmable length, built on a small memory.
module bmf_delay_line #(
  parameter int DEPTH = bmf_pkg::MAX_COLS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bmf_pkg::line_ctrl_t       ctrl,
  input  logic [$clog2(DEPTH+1)-1:0] length,
  input  logic                      din,
  output logic                      dout
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH+1);

  logic           mem [DEPTH];
  logic [AW-1:0]  ptr;
  logic [AW-1:0]  ptr_next;
  logic [LW-1:0]  last_idx;

  // pointer wraps at length-1
  assign last_idx = length - LW'(1);

  always_comb begin
    ptr_next = ptr;
    if (ctrl.restart) begin
      ptr_next = '0;
    end else if (ctrl.shift) begin
      if (LW'(ptr) == last_idx) begin
        ptr_next = '0;
      end else begin
        ptr_next = ptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      ptr <= ptr_next;
    end
  end

  // read old entry, then overwrite with the new sample
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      dout     <= mem[ptr];
      mem[ptr] <= din;
    end
  end

endmodule

// ===== rtl/core/binary_3x3_majority_filter.sv =====
// Top level of the streaming 3x3 binary majority (cave smoothing) filter.
//
// Cells enter on in_valid/in_ready in raster order, one item per cycle
// while in_ready is high; flush items shift in empty cells to drain the
// frame. Results leave on out_valid/out_ready in raster order, lagging the
// input stream by grid_cols+1 positions, so grid_cols+1 flush items follow
// each frame. frame_last marks the final cell of the frame.
// Inside the block the item that completes a window loads the window taps
// and the window stage; a move then loads the result into the output
// register. Throughput is one item per cycle while in_ready is high, set by
// the single write/read port of each line memory, which shifts once per item.
// When out_ready is low the output register holds its item, one more
// result waits in the window stage, and in_ready drops only when both are
// full. Configuration writes (cfg_valid, always ready) go to the threshold
// and grid size; a size write restarts the frame. Reset clears positions,
// handshake state and registers to their defaults; the line memories are
// not cleared.
module binary_3x3_majority_filter #(
  parameter int MAX_COLS = bmf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = bmf_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bmf_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bmf_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bmf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_COLS+1);
  localparam int ROW_W = $clog2(MAX_ROWS+2);
  localparam int CW    = (CNT_W > 8) ? CNT_W : 8;
  localparam int RW    = (ROW_W > 8) ? ROW_W : 8;

  // configuration registers
  logic [3:0] wall_threshold;
  logic [7:0] grid_cols;
  logic [7:0] grid_rows;

  // raster position of the next input
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;

  // window taps: newest row, middle row, oldest row
  logic new0, new1, new2;
  logic mid0, mid1, mid2;
  logic old0, old1, old2;

  // window stage and output stage
  logic s1_valid, s1_last, s1_border;

  logic accept, move, cfg_write;
  logic sample;
  bmf_pkg::line_ctrl_t line_ctrl;

  logic [CW-1:0]    cols_w;
  logic [RW-1:0]    rows_w;
  logic [CNT_W-1:0] cols_eff;
  logic [ROW_W-1:0] rows_eff;
  logic [COL_W-1:0] cols_m1;
  logic [ROW_W-1:0] rows_m1;

  logic             col_nz;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic             produced, last, border;
  logic [3:0]       count;
  logic             value;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  // handshakes
  assign move     = s1_valid & (~out_valid | out_ready);
  assign in_ready = ~s1_valid | ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;
  assign sample   = in_data.flush ? 1'b0 : in_data.cell_in;

  // grid size saturated to the supported range
  always_comb begin
    cols_w = CW'(grid_cols);
    if (cols_w < CW'(bmf_pkg::MIN_SIDE)) begin
      cols_w = CW'(bmf_pkg::MIN_SIDE);
    end else if (cols_w > CW'(MAX_COLS)) begin
      cols_w = CW'(MAX_COLS);
    end
    rows_w = RW'(grid_rows);
    if (rows_w < RW'(bmf_pkg::MIN_SIDE)) begin
      rows_w = RW'(bmf_pkg::MIN_SIDE);
    end else if (rows_w > RW'(MAX_ROWS)) begin
      rows_w = RW'(MAX_ROWS);
    end
  end

  assign cols_eff = CNT_W'(cols_w);
  assign rows_eff = ROW_W'(rows_w);
  assign cols_m1  = COL_W'(cols_eff - CNT_W'(1));
  assign rows_m1  = rows_eff - ROW_W'(1);

  // position of the result this item completes
  assign col_nz  = (col_pos != '0);
  assign out_col = col_nz ? (col_pos - COL_W'(1)) : cols_m1;
  assign out_row = col_nz ? (row_pos - ROW_W'(1)) : (row_pos - ROW_W'(2));

  always_comb begin
    if (col_nz) begin
      produced = (row_pos >= ROW_W'(1)) && (row_pos <= rows_eff);
    end else begin
      produced = (row_pos >= ROW_W'(2)) && (row_pos <= (rows_eff + ROW_W'(1)));
    end
  end

  assign last   = (out_row == rows_m1) && (out_col == cols_m1);
  assign border = (out_row == '0) || (out_row == rows_m1) ||
                  (out_col == '0) || (out_col == cols_m1);

  // configuration and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_threshold <= bmf_pkg::RESET_THRESHOLD;
      grid_cols      <= bmf_pkg::RESET_COLS;
      grid_rows      <= bmf_pkg::RESET_ROWS;
      col_pos        <= '0;
      row_pos        <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bmf_pkg::REG_WALL_THRESHOLD: begin
          wall_threshold <= cfg_data[3:0];
        end
        bmf_pkg::REG_GRID_COLS: begin
          grid_cols <= cfg_data;
          col_pos   <= '0;
          row_pos   <= '0;
        end
        bmf_pkg::REG_GRID_ROWS: begin
          grid_rows <= cfg_data;
          col_pos   <= '0;
          row_pos   <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (produced && last) begin
        col_pos <= '0;
        row_pos <= '0;
      end else if (col_pos == cols_m1) begin
        col_pos <= '0;
        row_pos <= row_pos + ROW_W'(1);
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

  // line memories: cols and cols-1 items of delay
  assign line_ctrl.shift   = accept;
  assign line_ctrl.restart = cfg_write && (cfg_index == bmf_pkg::REG_GRID_COLS);

  bmf_delay_line #(
    .DEPTH(MAX_COLS)
  ) u_line_mid (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (line_ctrl),
    .length(cols_eff),
    .din   (sample),
    .dout  (mid0)
  );

  bmf_delay_line #(
    .DEPTH(MAX_COLS)
  ) u_line_old (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (line_ctrl),
    .length(cols_eff - CNT_W'(1)),
    .din   (mid0),
    .dout  (old0)
  );

  // window tap shift registers
  always_ff @(posedge clk) begin
    if (accept) begin
      new0 <= sample;
      new1 <= new0;
      new2 <= new1;
      mid1 <= mid0;
      mid2 <= mid1;
      old1 <= old0;
      old2 <= old1;
    end
  end

  // window stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= produced;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last   <= last;
      s1_border <= border;
    end
  end

  // wall count over the window
  assign count = 4'(new0) + 4'(new1) + 4'(new2) +
                 4'(mid0) + 4'(mid1) + 4'(mid2) +
                 4'(old0) + 4'(old1) + 4'(old2);
  assign value = s1_border ? mid1 : (count >= wall_threshold);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data.cell_out   <= value;
      out_data.frame_last <= s1_last;
    end
  end

endmodule
